/* hdl/bds_pkg.sv */
// bds_pkg: types, codes and fixed widths for the bolus dose sequencer.
// No dependencies; bds_if, bds_ctrl and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

  localparam int AMOUNT_W   = 16;
  localparam int MIN_W      = 10;
  localparam int FULL_W     = 11;
  localparam int STEPS_W    = 8;
  localparam int STATUS_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [MIN_W-1:0]   RST_MIN_SIZE   = 10'd25;
  localparam logic [FULL_W-1:0]  RST_FULL_SIZE  = 11'd50;
  localparam logic [STEPS_W-1:0] RST_FULL_STEPS = 8'd36;
  localparam logic [STEPS_W-1:0] RST_HALF_STEPS = 8'd18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SIZE   = 2'd0,
    CFG_FULL_SIZE  = 2'd1,
    CFG_FULL_STEPS = 2'd2,
    CFG_HALF_STEPS = 2'd3
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE          = 4'd0,
    ST_ACCEPTED      = 4'd1,
    ST_ZERO          = 4'd2,
    ST_WAIT_MOTOR    = 4'd3,
    ST_DOSE          = 4'd4,
    ST_HALF          = 4'd5,
    ST_FINISHED      = 4'd6,
    ST_USER_CANCEL   = 4'd7,
    ST_SHRUNK_CANCEL = 4'd8,
    ST_END_CANCEL    = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DECIDE,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    OP_REQ,
    OP_START,
    OP_CHG,
    OP_FIN
  } op_e;

  // granules already mapped so that zero acts as one
  typedef struct packed {
    logic [FULL_W-1:0]  gmin;
    logic [FULL_W-1:0]  gfull;
    logic [STEPS_W-1:0] full_steps;
    logic [STEPS_W-1:0] half_steps;
  } cfg_t;

  typedef struct packed {
    logic [STEPS_W-1:0] step_count;
    logic               motor_held;
    status_e            status;
  } res_t;

  function automatic res_t mk_res(logic [STEPS_W-1:0] steps, logic held, status_e st);
    res_t r;
    r.step_count = steps;
    r.motor_held = held;
    r.status     = st;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/bds_if.sv */
// bds_if: valid/ready channel interfaces for request/tick items and results.
// Depends on bds_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bds_in_if;
  import bds_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [AMOUNT_W-1:0] amount;
  logic                plunger_at_end;
  logic                motor_free;

  modport source (output valid, func, amount, plunger_at_end, motor_free, input ready);
  modport sink   (input valid, func, amount, plunger_at_end, motor_free, output ready);
endinterface

interface bds_out_if;
  import bds_pkg::*;

  logic                valid;
  logic                ready;
  logic [STEPS_W-1:0]  step_count;
  logic                motor_held;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, step_count, motor_held, status, last, input ready);
  modport sink   (input valid, step_count, motor_held, status, last, output ready);
endinterface

`default_nettype wire

/* hdl/bds_div.sv */
// bds_div: bit-serial restoring divider, one quotient bit per cycle.
// Standalone; quotient and remainder are valid while done_o is high.
`timescale 1ns / 1ps
`default_nettype none

module bds_div #(
  parameter int DW = 16,
  parameter int VW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DW-1:0]      quot_o,
  output logic [VW-1:0]      rem_o
);

  localparam int CNT_W = $clog2(DW);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    quo_q;
  logic [VW-1:0]    rem_q;
  logic [VW-1:0]    dvs_q;
  logic [VW:0]      trial, diff;
  logic             fits;

  // next dividend bit shifts into the partial remainder
  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* hdl/bds_ctrl.sv */
// bds_ctrl: bolus sequencing state machine, bolus state and result register.
// Depends on bds_pkg, bds_if and an external bds_div for all divisions.
`timescale 1ns / 1ps
`default_nettype none

module bds_ctrl #(
  parameter int SIZE_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bds_pkg::cfg_t                cfg_i,
  bds_in_if.sink                            in_i,
  bds_out_if.source                         out_o,
  output logic                              div_start_o,
  output logic [SIZE_BITS-1:0]              div_dividend_o,
  output logic [bds_pkg::FULL_W-1:0]        div_divisor_o,
  input  wire logic                         div_busy_i,
  input  wire logic                         div_done_i,
  input  wire logic [SIZE_BITS-1:0]         div_quot_i,
  input  wire logic [bds_pkg::FULL_W-1:0]   div_rem_i
);
  import bds_pkg::*;

  localparam int NUM_W = SIZE_BITS + 1;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic                 delivering_q, delivering_d;
  logic [SIZE_BITS-1:0] pending_q, pending_d;
  logic [SIZE_BITS-1:0] working_q, working_d;
  logic [SIZE_BITS-1:0] total_q, total_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [SIZE_BITS-1:0] amt_q, amt_d;
  logic                 at_end_q, at_end_d;
  res_t                 res0_q, res0_d, res1_q, res1_d;
  logic                 two_q, two_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 out_q, out_d;
  logic                 out_last_q, out_last_d;

  logic                 accept, out_free, over, stop;
  logic [SIZE_BITS-1:0] amt_in, req_size;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign amt_in     = SIZE_BITS'(in_i.amount);
  // amount minus its remainder by the granule
  assign req_size   = amt_q - SIZE_BITS'(div_rem_i);
  assign over       = num_q > {1'b0, total_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!in_i.func) state_d = S_DIV;
          else if (delivering_q) state_d = S_DECIDE;
          else if (pending_q == '0 || !in_i.motor_free) state_d = S_EMIT;
          else state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done_i) state_d = (op_q == OP_START) ? S_DECIDE : S_EMIT;
      end
      S_DECIDE: begin
        if (over || (pending_q != '0 && pending_q != working_q)) state_d = S_DIV;
        else state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free && !two_q) state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    op_d           = op_q;
    delivering_d   = delivering_q;
    pending_d      = pending_q;
    working_d      = working_q;
    total_d        = total_q;
    num_d          = num_q;
    amt_d          = amt_q;
    at_end_d       = at_end_q;
    res0_d         = res0_q;
    res1_d         = res1_q;
    two_d          = two_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_d          = out_q;
    out_last_d     = out_last_q;
    div_start_o    = 1'b0;
    div_dividend_o = pending_q;
    div_divisor_o  = cfg_i.gfull;
    stop           = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          amt_d    = amt_in;
          at_end_d = in_i.plunger_at_end;
          two_d    = 1'b0;
          if (!in_i.func) begin
            op_d           = OP_REQ;
            div_start_o    = 1'b1;
            div_dividend_o = amt_in;
            div_divisor_o  = cfg_i.gmin;
          end else if (!delivering_q) begin
            if (pending_q == '0) begin
              res0_d = mk_res('0, 1'b0, ST_IDLE);
            end else if (!in_i.motor_free) begin
              res0_d = mk_res('0, 1'b0, ST_WAIT_MOTOR);
            end else begin
              op_d        = OP_START;
              div_start_o = 1'b1;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done_i) begin
          unique case (op_q)
            OP_REQ: begin
              pending_d = req_size;
              res0_d    = mk_res('0, delivering_q,
                                 (req_size != '0) ? ST_ACCEPTED : ST_ZERO);
            end
            OP_START: begin
              working_d    = pending_q;
              total_d      = div_quot_i;
              num_d        = NUM_W'(1);
              delivering_d = 1'b1;
            end
            OP_CHG: begin
              // new size is taken only if its dose count still reaches this dose
              if ({1'b0, div_quot_i} >= num_q) begin
                working_d = pending_q;
                total_d   = div_quot_i;
                num_d     = num_q + NUM_W'(1);
                res0_d    = mk_res(cfg_i.full_steps, 1'b1, ST_DOSE);
              end else begin
                res0_d = mk_res('0, 1'b0, ST_SHRUNK_CANCEL);
                stop   = 1'b1;
              end
            end
            OP_FIN: begin
              // remainder of the working size by the current full dose size
              stop = 1'b1;
              if (div_rem_i == cfg_i.gmin) begin
                res0_d = mk_res(cfg_i.half_steps, 1'b1, ST_HALF);
                res1_d = mk_res('0, 1'b0, ST_FINISHED);
                two_d  = 1'b1;
              end else begin
                res0_d = mk_res('0, 1'b0, ST_FINISHED);
              end
            end
          endcase
        end
      end
      S_DECIDE: begin
        if (over) begin
          op_d           = OP_FIN;
          div_start_o    = 1'b1;
          div_dividend_o = working_q;
        end else if (pending_q == '0) begin
          res0_d = mk_res('0, 1'b0, ST_USER_CANCEL);
          stop   = 1'b1;
        end else if (pending_q != working_q) begin
          op_d        = OP_CHG;
          div_start_o = 1'b1;
        end else if (at_end_q) begin
          res0_d = mk_res('0, 1'b0, ST_END_CANCEL);
          stop   = 1'b1;
        end else begin
          res0_d = mk_res(cfg_i.full_steps, 1'b1, ST_DOSE);
          num_d  = num_q + NUM_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res0_q;
          out_last_d  = !two_q;
          if (two_q) begin
            res0_d = res1_q;
            two_d  = 1'b0;
          end
        end
      end
    endcase

    if (stop) begin
      delivering_d = 1'b0;
      pending_d    = '0;
      working_d    = '0;
      total_d      = '0;
      num_d        = NUM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_REQ;
      delivering_q <= 1'b0;
      pending_q    <= '0;
      working_q    <= '0;
      total_q      <= '0;
      num_q        <= NUM_W'(1);
      two_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      delivering_q <= delivering_d;
      pending_q    <= pending_d;
      working_q    <= working_d;
      total_q      <= total_d;
      num_q        <= num_d;
      two_q        <= two_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amt_q      <= amt_d;
    at_end_q   <= at_end_d;
    res0_q     <= res0_d;
    res1_q     <= res1_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.step_count = out_q.step_count;
  assign out_o.motor_held = out_q.motor_held;
  assign out_o.status     = out_q.status;
  assign out_o.last       = out_last_q;

  a_num_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delivering_q |-> num_q <= {1'b0, total_q} + NUM_W'(1))
    else $error("dose number ran past dose total");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !delivering_q |-> (working_q == '0 && total_q == '0 && num_q == NUM_W'(1)))
    else $error("bolus state left over while not delivering");

  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> (div_busy_i || div_done_i))
    else $error("waiting on a divider that is not running");

  a_pair_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && two_q) |=> state_q == S_EMIT)
    else $error("second result of a pair dropped");

endmodule

`default_nettype wire

/* hdl/bolus_dose_sequencer_top.sv */
// bolus_dose_sequencer_top: config registers, sequencer and shared serial divider.
// A request takes one division by the min granule; a tick answers without a division when
// idle or waiting, for a plain dose or a cancel, divides when a bolus starts, changes size
// or ends, and divides twice when a bolus starts and ends on one tick; a half dose adds a result.
// The serial divider (one bit a cycle) does all divisions. One item at a time; input ready
// again right after its last result is registered. Reset (async, active low) loads defaults.
`timescale 1ns / 1ps
`default_nettype none

module bolus_dose_sequencer_top #(
  parameter int SIZE_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bds_in_if.sink                              in_i,
  bds_out_if.source                           out_o
);
  import bds_pkg::*;

  logic [MIN_W-1:0]     min_size_q;
  logic [FULL_W-1:0]    full_size_q;
  logic [STEPS_W-1:0]   full_steps_q;
  logic [STEPS_W-1:0]   half_steps_q;
  cfg_t                 cfg;

  logic                 div_start, div_busy, div_done;
  logic [SIZE_BITS-1:0] div_dividend, div_quot;
  logic [FULL_W-1:0]    div_divisor, div_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q   <= RST_MIN_SIZE;
      full_size_q  <= RST_FULL_SIZE;
      full_steps_q <= RST_FULL_STEPS;
      half_steps_q <= RST_HALF_STEPS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_SIZE:   min_size_q   <= cfg_data_i[MIN_W-1:0];
        CFG_FULL_SIZE:  full_size_q  <= cfg_data_i[FULL_W-1:0];
        CFG_FULL_STEPS: full_steps_q <= cfg_data_i[STEPS_W-1:0];
        CFG_HALF_STEPS: half_steps_q <= cfg_data_i[STEPS_W-1:0];
      endcase
    end
  end

  // a zero granule behaves as one
  assign cfg.gmin       = (min_size_q == '0) ? FULL_W'(1) : FULL_W'(min_size_q);
  assign cfg.gfull      = (full_size_q == '0) ? FULL_W'(1) : full_size_q;
  assign cfg.full_steps = full_steps_q;
  assign cfg.half_steps = half_steps_q;

  bds_ctrl #(
    .SIZE_BITS (SIZE_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_i           (in_i),
    .out_o          (out_o),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_busy_i     (div_busy),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .div_rem_i      (div_rem)
  );

  bds_div #(
    .DW (SIZE_BITS),
    .VW (FULL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

endmodule

`default_nettype wire

/* verif/bds_tb_pkg.sv */
// bds_tb_pkg: item codes shared by the bolus dose sequencer testbench files.
// No dependencies.
`timescale 1ns / 1ps

package bds_tb_pkg;

  localparam logic FN_REQUEST = 1'b0;
  localparam logic FN_TICK    = 1'b1;

endpackage

/* verif/bds_dose_checker.sv */
// bds_dose_checker: watches the item, result and register channels, predicts the
// doses of every accepted item and compares them with the results in order.
// Depends on bds_pkg, bds_tb_pkg and the channel interfaces of bds_if.
`timescale 1ns / 1ps

module bds_dose_checker
  import bds_pkg::*;
  import bds_tb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bds_in_if                     in_ch,
  bds_out_if                    out_ch,
  output int unsigned           err_cnt_o,
  output int unsigned           open_cnt_o
);

  typedef struct packed {
    logic [STEPS_W-1:0] steps;
    logic               held;
    status_e            status;
    logic               last;
  } dose_res_t;

  logic [MIN_W-1:0]    min_sz;
  logic [FULL_W-1:0]   full_sz;
  logic [STEPS_W-1:0]  full_steps;
  logic [STEPS_W-1:0]  half_steps;
  logic [AMOUNT_W-1:0] pend_sz;
  logic [AMOUNT_W-1:0] work_sz;
  logic [AMOUNT_W-1:0] dose_tot;
  logic [AMOUNT_W:0]   dose_num;
  logic                delivering;
  dose_res_t           due_results_q[$];

  function automatic int unsigned granule(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  task automatic report(input string msg);
    err_cnt_o++;
    if (err_cnt_o <= 10) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic add_result(input logic [STEPS_W-1:0] s, input logic h, input status_e st,
                            input logic l);
    dose_res_t r;
    r.steps  = s;
    r.held   = h;
    r.status = st;
    r.last   = l;
    due_results_q.push_back(r);
  endtask

  task automatic end_bolus();
    delivering = 1'b0;
    pend_sz    = '0;
    work_sz    = '0;
    dose_tot   = '0;
    dose_num   = 1;
  endtask

  task automatic predict_dose(input logic fn, input logic [AMOUNT_W-1:0] amt,
                              input logic at_end, input logic free);
    int unsigned gmin;
    int unsigned gfull;
    int unsigned trunc;
    int unsigned new_tot;
    gmin  = granule(min_sz);
    gfull = granule(full_sz);
    if (fn == FN_REQUEST) begin
      trunc   = (amt / gmin) * gmin;
      pend_sz = trunc[AMOUNT_W-1:0];
      add_result('0, delivering, (trunc != 0) ? ST_ACCEPTED : ST_ZERO, 1'b1);
      return;
    end
    if (!delivering) begin
      if (pend_sz == 0) begin
        add_result('0, 1'b0, ST_IDLE, 1'b1);
        return;
      end
      if (!free) begin
        add_result('0, 1'b0, ST_WAIT_MOTOR, 1'b1);
        return;
      end
      work_sz    = pend_sz;
      trunc      = work_sz / gfull;
      dose_tot   = trunc[AMOUNT_W-1:0];
      dose_num   = 1;
      delivering = 1'b1;
    end
    if (dose_num > dose_tot) begin
      if (work_sz % gfull == gmin) add_result(half_steps, 1'b1, ST_HALF, 1'b0);
      add_result('0, 1'b0, ST_FINISHED, 1'b1);
      end_bolus();
    end else if (pend_sz == 0) begin
      add_result('0, 1'b0, ST_USER_CANCEL, 1'b1);
      end_bolus();
    end else if (pend_sz != work_sz) begin
      // a changed size skips the plunger check when the dose count still holds
      new_tot = pend_sz / gfull;
      if (dose_num <= new_tot) begin
        work_sz  = pend_sz;
        dose_tot = new_tot[AMOUNT_W-1:0];
        add_result(full_steps, 1'b1, ST_DOSE, 1'b1);
        dose_num++;
      end else begin
        add_result('0, 1'b0, ST_SHRUNK_CANCEL, 1'b1);
        end_bolus();
      end
    end else if (at_end) begin
      add_result('0, 1'b0, ST_END_CANCEL, 1'b1);
      end_bolus();
    end else begin
      add_result(full_steps, 1'b1, ST_DOSE, 1'b1);
      dose_num++;
    end
  endtask

  task automatic check_result();
    dose_res_t e;
    if (due_results_q.size() == 0) begin
      report($sformatf("result with nothing due: steps %0d held %0b status %0d last %0b",
                       out_ch.step_count, out_ch.motor_held, out_ch.status, out_ch.last));
      return;
    end
    e = due_results_q.pop_front();
    if (out_ch.step_count !== e.steps || out_ch.motor_held !== e.held ||
        out_ch.status !== e.status || out_ch.last !== e.last)
      report($sformatf({"expected steps %0d held %0b status %0d last %0b, ",
                        "got steps %0d held %0b status %0d last %0b"},
                       e.steps, e.held, e.status, e.last, out_ch.step_count,
                       out_ch.motor_held, out_ch.status, out_ch.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sz     = RST_MIN_SIZE;
      full_sz    = RST_FULL_SIZE;
      full_steps = RST_FULL_STEPS;
      half_steps = RST_HALF_STEPS;
      end_bolus();
      due_results_q.delete();
      err_cnt_o  = 0;
      open_cnt_o = 0;
    end else begin
      // only one item is in flight, so a result at this edge never belongs to the item
      // accepted at the same edge
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_SIZE:   min_sz     = cfg_data_i[MIN_W-1:0];
          CFG_FULL_SIZE:  full_sz    = cfg_data_i[FULL_W-1:0];
          CFG_FULL_STEPS: full_steps = cfg_data_i[STEPS_W-1:0];
          CFG_HALF_STEPS: half_steps = cfg_data_i[STEPS_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        predict_dose(in_ch.func, in_ch.amount, in_ch.plunger_at_end, in_ch.motor_free);
      open_cnt_o = due_results_q.size();
    end
  end

endmodule

/* verif/tb_bolus_dose_sequencer_top.sv */
// tb_bolus_dose_sequencer_top: clock, reset, register writes and item stimulus for
// the bolus dose sequencer; checking is done by bds_dose_checker beside the block.
// Depends on bds_pkg, bds_tb_pkg, bds_if, bds_dose_checker and the block itself.
`timescale 1ns / 1ps

module tb_bolus_dose_sequencer_top;
  import bds_pkg::*;
  import bds_tb_pkg::*;

  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned DRAIN_CYCLES     = 60;
  localparam int unsigned ITEMS_PER_PHASE  = 72;
  localparam int          NUM_PHASES       = 7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned err_cnt;
  int unsigned open_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cur_gmin;
  int unsigned cur_gfull;
  int unsigned items_sent;
  int unsigned hold_cnt;
  logic        hold_req;

  bds_in_if  in_ch ();
  bds_out_if out_ch ();

  bolus_dose_sequencer_top #(
    .SIZE_BITS(16)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  bds_dose_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .err_cnt_o  (err_cnt),
    .open_cnt_o (open_cnt)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic fn, input logic [AMOUNT_W-1:0] amt,
                           input logic at_end, input logic free);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= fn;
    in_ch.amount         <= amt;
    in_ch.plunger_at_end <= at_end;
    in_ch.motor_free     <= free;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic request(input logic [AMOUNT_W-1:0] amt);
    send_item(FN_REQUEST, amt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic tick(input logic at_end, input logic free);
    send_item(FN_TICK, AMOUNT_W'($urandom_range(0, 65535)), at_end, free);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned mn, input int unsigned fl,
                               input int unsigned fs, input int unsigned hs);
    write_reg(CFG_MIN_SIZE, mn[CFG_DATA_W-1:0]);
    write_reg(CFG_FULL_SIZE, fl[CFG_DATA_W-1:0]);
    write_reg(CFG_FULL_STEPS, fs[CFG_DATA_W-1:0]);
    write_reg(CFG_HALF_STEPS, hs[CFG_DATA_W-1:0]);
    cfg_we_i  <= 1'b0;
    cur_gmin  = (mn[MIN_W-1:0] == 0) ? 1 : mn[MIN_W-1:0];
    cur_gfull = (fl[FULL_W-1:0] == 0) ? 1 : fl[FULL_W-1:0];
  endtask

  initial begin
    int unsigned k;
    int unsigned amt;
    int unsigned n_ticks;
    int unsigned roll;
    int unsigned target;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_MIN_SIZE;
    cfg_data_i           = '0;
    in_ch.valid          = 1'b0;
    in_ch.func           = FN_REQUEST;
    in_ch.amount         = '0;
    in_ch.plunger_at_end = 1'b0;
    in_ch.motor_free     = 1'b0;
    out_ch.ready         = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    cur_gmin             = RST_MIN_SIZE;
    cur_gfull            = RST_FULL_SIZE;
    items_sent           = 0;
    hold_req             = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part on the reset register values
    tick(1'b0, 1'b1);
    request(16'd0);
    request(16'hFFFF);
    tick(1'b0, 1'b0);
    tick(1'b0, 1'b1);
    request(16'd30);
    tick(1'b0, 1'b1);
    // two full doses and a half dose
    request(16'd125);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    // grow the bolus, then hit the plunger end
    request(16'd100);
    tick(1'b0, 1'b1);
    request(16'd200);
    tick(1'b0, 1'b1);
    tick(1'b1, 1'b1);
    // user cancel while delivering
    request(16'd100);
    tick(1'b0, 1'b1);
    request(16'd0);
    tick(1'b0, 1'b1);
    // size change on the same tick as the plunger end
    request(16'd100);
    tick(1'b0, 1'b1);
    request(16'd150);
    tick(1'b1, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_ch.valid <= 1'b0;
      while (open_cnt != 0) @(negedge clk_i);
      repeat (DRAIN_CYCLES) @(negedge clk_i);
      case (ph)
        1: apply_setting(1, 1, 255, 0);
        2: apply_setting(1000, 2000, 0, 255);
        3: apply_setting(0, 0, 7, 200);
        4: apply_setting(1023, 2047, 128, 1);
        5: begin
          k = $urandom_range(1, 300);
          apply_setting(k, k * $urandom_range(2, 6), $urandom_range(0, 255),
                        $urandom_range(0, 255));
        end
        6: begin
          k = $urandom_range(1, 50);
          apply_setting(k, 2 * k, $urandom_range(0, 255), $urandom_range(0, 255));
        end
        default: ;
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      // long receiver hold-off with the sender still pushing items
      if (ph == 0) hold_req = 1'b1;

      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 4))
            send_item(1'($urandom_range(0, 1)), AMOUNT_W'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          // a bolus: request shaped to a few doses, then ticks with rare interruptions
          k = $urandom_range(0, 5);
          case ($urandom_range(0, 3))
            0: amt = k * cur_gfull;
            1: amt = k * cur_gfull + cur_gmin;
            2: amt = k * cur_gfull + $urandom_range(0, cur_gfull - 1);
            default: amt = k * cur_gfull + cur_gmin + $urandom_range(0, cur_gmin - 1);
          endcase
          if (amt > 65535) amt = 65535;
          request(amt[AMOUNT_W-1:0]);
          n_ticks = k + 2 + $urandom_range(0, 2);
          for (int i = 0; i < n_ticks; i++) begin
            roll = $urandom_range(99);
            if (roll < 7) begin
              case ($urandom_range(0, 4))
                0: begin
                  amt = amt + cur_gfull * $urandom_range(1, 2);
                  n_ticks += 2;
                end
                1: amt = (amt > cur_gfull) ? amt - cur_gfull : 0;
                2: amt = 0;
                3: ;
                default: amt = $urandom_range(0, 65535);
              endcase
              if (amt > 65535) amt = 65535;
              request(amt[AMOUNT_W-1:0]);
            end else begin
              tick($urandom_range(99) < 5, $urandom_range(99) < 88);
            end
          end
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (open_cnt != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
hdl/bds_pkg.sv
hdl/bds_if.sv
hdl/bds_div.sv
hdl/bds_ctrl.sv
hdl/bolus_dose_sequencer_top.sv
verif/bds_tb_pkg.sv
verif/bds_dose_checker.sv
verif/tb_bolus_dose_sequencer_top.sv
